// ----- rtl/core/dsst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dsst_pkg
// Shared types and constants for the depth sorted slot table.
// ============================================================================
package dsst_pkg;

    localparam int SLOTS_DEF       = 4096;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int DEPTH_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_CLEAR  = 3'd2,
        REQ_SORT   = 3'd3,
        REQ_READ   = 3'd4
    } t_req;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_ADD_RD,
        S_ADD_CHK,
        S_REM_RD,
        S_REM_CHK,
        S_READ_RD,
        S_READ_CHK,
        S_CLR,
        S_CMP_RD,
        S_CMP_CHK,
        S_MRG_INIT,
        S_PASS_CHK,
        S_MRG_RD,
        S_MRG_WR,
        S_RUN_NEXT,
        S_RUN_CHK,
        S_WB_RD,
        S_WB_WR,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SWEEP_CLR,
        OP_ADV,
        OP_ADD_PLACE,
        OP_REM_TAKE,
        OP_READ_TAKE,
        OP_CMP_STEP,
        OP_MRG_INIT,
        OP_RUN_SETUP,
        OP_MRG_RD,
        OP_MRG_WR,
        OP_RUN_NEXT,
        OP_PASS_NEXT,
        OP_WB_INIT,
        OP_WB_WR,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   read_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic free_hit;
        logic match_hit;
        logic scan_last;
        logic pass_done;
        logic lo_end;
        logic k_last;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- rtl/core/dsst_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dsst_ctrl
// Sequencer for the slot table: handshakes and operation steps.
// ============================================================================
module dsst_ctrl
    import dsst_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_req_type,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    t_state r_state, n_state;
    logic   r_ov;
    logic   w_emit;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign w_emit  = (r_state == S_DONE) && (!r_ov || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:     if (i_status.scan_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_req_type)
                        REQ_ADD:    n_state = S_ADD_RD;
                        REQ_REMOVE: n_state = S_REM_RD;
                        REQ_CLEAR:  n_state = S_CLR;
                        REQ_SORT:   n_state = S_CMP_RD;
                        REQ_READ:   n_state = S_READ_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_ADD_RD:   n_state = S_ADD_CHK;
            S_ADD_CHK: begin
                if (i_status.free_hit || i_status.scan_last) n_state = S_DONE;
                else n_state = S_ADD_RD;
            end
            S_REM_RD:   n_state = S_REM_CHK;
            S_REM_CHK: begin
                if (i_status.match_hit || i_status.scan_last) n_state = S_DONE;
                else n_state = S_REM_RD;
            end
            S_READ_RD:  n_state = S_READ_CHK;
            S_READ_CHK: n_state = S_DONE;
            S_CLR:      if (i_status.scan_last) n_state = S_DONE;
            S_CMP_RD:   n_state = S_CMP_CHK;
            S_CMP_CHK: begin
                if (i_status.scan_last) n_state = S_MRG_INIT;
                else n_state = S_CMP_RD;
            end
            S_MRG_INIT: n_state = S_PASS_CHK;
            S_PASS_CHK: begin
                if (i_status.pass_done) n_state = S_WB_RD;
                else n_state = S_MRG_RD;
            end
            S_MRG_RD:   n_state = S_MRG_WR;
            S_MRG_WR: begin
                if (i_status.k_last) n_state = S_RUN_NEXT;
                else n_state = S_MRG_RD;
            end
            S_RUN_NEXT: n_state = S_RUN_CHK;
            S_RUN_CHK: begin
                if (i_status.lo_end) n_state = S_PASS_CHK;
                else n_state = S_MRG_RD;
            end
            S_WB_RD:    n_state = S_WB_WR;
            S_WB_WR: begin
                if (i_status.scan_last) n_state = S_DONE;
                else n_state = S_WB_RD;
            end
            S_DONE:     if (w_emit) n_state = S_IDLE;
            default:    n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.read_sel = (r_state == S_READ_RD);
        unique case (r_state)
            S_INIT:     o_cmd.op = OP_SWEEP_CLR;
            S_IDLE:     if (i_valid) o_cmd.op = OP_LOAD;
            S_ADD_CHK: begin
                if (i_status.free_hit) o_cmd.op = OP_ADD_PLACE;
                else if (!i_status.scan_last) o_cmd.op = OP_ADV;
            end
            S_REM_CHK: begin
                if (i_status.match_hit) o_cmd.op = OP_REM_TAKE;
                else if (!i_status.scan_last) o_cmd.op = OP_ADV;
            end
            S_READ_CHK: o_cmd.op = OP_READ_TAKE;
            S_CLR:      o_cmd.op = OP_SWEEP_CLR;
            S_CMP_CHK:  o_cmd.op = OP_CMP_STEP;
            S_MRG_INIT: o_cmd.op = OP_MRG_INIT;
            S_PASS_CHK: o_cmd.op = i_status.pass_done ? OP_WB_INIT : OP_RUN_SETUP;
            S_MRG_RD:   o_cmd.op = OP_MRG_RD;
            S_MRG_WR:   o_cmd.op = OP_MRG_WR;
            S_RUN_NEXT: o_cmd.op = OP_RUN_NEXT;
            S_RUN_CHK:  o_cmd.op = i_status.lo_end ? OP_PASS_NEXT : OP_RUN_SETUP;
            S_WB_WR:    o_cmd.op = OP_WB_WR;
            S_DONE:     if (w_emit) o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/dsst_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dsst_dp
// Slot table storage, sort buffers, scan counters and result registers.
// ============================================================================
module dsst_dp
    import dsst_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
    localparam int SB = $clog2(SLOTS),
    localparam int CB = $clog2(SLOTS + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_status                        o_status,
    input  wire logic [HANDLE_BITS-1:0]       i_entity_id,
    input  wire logic signed [DEPTH_BITS-1:0] i_entity_depth,
    input  wire logic [SB-1:0]                i_slot_index,
    output logic [SB-1:0]                     o_slot_number,
    output logic                              o_success,
    output logic [HANDLE_BITS-1:0]            o_slot_entity,
    output logic signed [DEPTH_BITS-1:0]      o_slot_depth,
    output logic                              o_slot_occupied,
    output logic [CB-1:0]                     o_entry_count,
    output logic                              o_needs_sort
);

    localparam int EW = HANDLE_BITS + DEPTH_BITS;
    localparam int LW = CB + 3;

    logic [EW:0]   mem_m  [SLOTS];
    logic [EW-1:0] mem_s0 [SLOTS];
    logic [EW-1:0] mem_s1 [SLOTS];

    logic [EW:0]   r_rd_m;
    logic [EW-1:0] r_rd_p0, r_rd_p1, r_rd_q0, r_rd_q1;

    logic [CB-1:0] r_i, r_n, r_p, r_q, r_k, r_mid, r_hi;
    logic [LW-1:0] r_lo, r_w;
    logic          r_sel;
    logic [CB-1:0] r_total;
    logic          r_dirty;

    logic [HANDLE_BITS-1:0] r_h;
    logic [DEPTH_BITS-1:0]  r_d;
    logic [SB-1:0]          r_idx;

    logic [SB-1:0]          r_res_slot;
    logic                   r_res_ok;
    logic [HANDLE_BITS-1:0] r_res_ent;
    logic [DEPTH_BITS-1:0]  r_res_dep;
    logic                   r_res_occ;

    logic                   m_occ;
    logic [HANDLE_BITS-1:0] m_h;
    logic [EW-1:0]          src_p, src_q;
    logic                   p_ok, q_ok, take_q;
    logic                   idx_ok;
    logic [SB-1:0]          addr_m, addr_p;
    logic                   m_we;
    logic [EW:0]            m_wd;
    logic [LW-1:0]          t_mid, t_hi, n_ext;

    assign m_occ  = r_rd_m[EW];
    assign m_h    = r_rd_m[EW-1:DEPTH_BITS];
    assign src_p  = r_sel ? r_rd_p1 : r_rd_p0;
    assign src_q  = r_sel ? r_rd_q1 : r_rd_q0;
    assign p_ok   = r_p < r_mid;
    assign q_ok   = r_q < r_hi;
    assign take_q = q_ok && (!p_ok ||
        ($signed(src_q[DEPTH_BITS-1:0]) < $signed(src_p[DEPTH_BITS-1:0])));
    assign idx_ok = {1'b0, r_idx} < CB'(SLOTS);
    assign n_ext  = LW'(r_n);
    assign t_mid  = ((r_lo + r_w) < n_ext) ? (r_lo + r_w) : n_ext;
    assign t_hi   = ((r_lo + (r_w << 1)) < n_ext) ? (r_lo + (r_w << 1)) : n_ext;

    assign addr_m = i_cmd.read_sel ? r_idx : r_i[SB-1:0];
    assign addr_p = (i_cmd.op == OP_MRG_RD) ? r_p[SB-1:0] : r_i[SB-1:0];

    always_comb begin
        m_we = 1'b0;
        m_wd = {1'b0, r_h, r_d};
        unique case (i_cmd.op)
            OP_SWEEP_CLR: m_we = 1'b1;
            OP_REM_TAKE:  m_we = 1'b1;
            OP_ADD_PLACE: begin
                m_we = 1'b1;
                m_wd = {1'b1, r_h, r_d};
            end
            OP_WB_WR: begin
                m_we = 1'b1;
                m_wd = {(r_i < r_n), src_p};
            end
            default: m_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem_m[r_i[SB-1:0]] <= m_wd;
        end
        r_rd_m <= mem_m[addr_m];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CMP_STEP && m_occ) begin
            mem_s0[r_n[SB-1:0]] <= r_rd_m[EW-1:0];
        end else if (i_cmd.op == OP_MRG_WR && r_sel) begin
            mem_s0[r_k[SB-1:0]] <= take_q ? src_q : src_p;
        end
        r_rd_p0 <= mem_s0[addr_p];
        r_rd_q0 <= mem_s0[r_q[SB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MRG_WR && !r_sel) begin
            mem_s1[r_k[SB-1:0]] <= take_q ? src_q : src_p;
        end
        r_rd_p1 <= mem_s1[addr_p];
        r_rd_q1 <= mem_s1[r_q[SB-1:0]];
    end

    always_comb begin
        o_status.free_hit  = !m_occ;
        o_status.match_hit = m_occ && (m_h == r_h);
        o_status.scan_last = (r_i == CB'(SLOTS - 1));
        o_status.pass_done = (r_w >= n_ext);
        o_status.lo_end    = (r_lo >= n_ext);
        o_status.k_last    = ((r_k + 1'b1) >= r_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i     <= '0;
            r_total <= '0;
            r_dirty <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_i        <= '0;
                    r_n        <= '0;
                    r_h        <= i_entity_id;
                    r_d        <= i_entity_depth;
                    r_idx      <= i_slot_index;
                    r_res_slot <= (i_cmd.read_sel) ? i_slot_index : '0;
                    r_res_ok   <= 1'b0;
                    r_res_ent  <= '0;
                    r_res_dep  <= '0;
                    r_res_occ  <= 1'b0;
                end
                OP_SWEEP_CLR: begin
                    r_i     <= o_status.scan_last ? '0 : r_i + 1'b1;
                    r_total <= '0;
                    r_dirty <= 1'b0;
                end
                OP_ADV: r_i <= r_i + 1'b1;
                OP_ADD_PLACE: begin
                    r_total    <= r_total + 1'b1;
                    r_dirty    <= 1'b1;
                    r_res_slot <= r_i[SB-1:0];
                    r_res_ok   <= 1'b1;
                end
                OP_REM_TAKE: begin
                    if (r_total != '0) r_total <= r_total - 1'b1;
                    r_dirty  <= 1'b1;
                    r_res_ok <= 1'b1;
                end
                OP_READ_TAKE: begin
                    r_res_slot <= r_idx;
                    if (idx_ok && m_occ) begin
                        r_res_occ <= 1'b1;
                        r_res_ent <= m_h;
                        r_res_dep <= r_rd_m[DEPTH_BITS-1:0];
                    end
                end
                OP_CMP_STEP: begin
                    if (m_occ) r_n <= r_n + 1'b1;
                    r_i <= r_i + 1'b1;
                end
                OP_MRG_INIT: begin
                    r_w   <= LW'(1);
                    r_lo  <= '0;
                    r_sel <= 1'b0;
                end
                OP_RUN_SETUP: begin
                    r_mid <= t_mid[CB-1:0];
                    r_hi  <= t_hi[CB-1:0];
                    r_p   <= r_lo[CB-1:0];
                    r_q   <= t_mid[CB-1:0];
                    r_k   <= r_lo[CB-1:0];
                end
                OP_MRG_WR: begin
                    if (take_q) r_q <= r_q + 1'b1;
                    else r_p <= r_p + 1'b1;
                    r_k <= r_k + 1'b1;
                end
                OP_RUN_NEXT: r_lo <= r_lo + (r_w << 1);
                OP_PASS_NEXT: begin
                    r_w   <= r_w << 1;
                    r_lo  <= '0;
                    r_sel <= !r_sel;
                end
                OP_WB_INIT: r_i <= '0;
                OP_WB_WR: begin
                    r_i     <= r_i + 1'b1;
                    r_total <= r_n;
                    r_dirty <= 1'b0;
                end
                OP_EMIT: begin
                    o_slot_number   <= r_res_slot;
                    o_success       <= r_res_ok;
                    o_slot_entity   <= r_res_ent;
                    o_slot_depth    <= r_res_dep;
                    o_slot_occupied <= r_res_occ;
                    o_entry_count   <= r_total;
                    o_needs_sort    <= r_dirty;
                end
                default: r_i <= r_i;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/depth_sorted_slot_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// depth_sorted_slot_table
// Draw-list slot table with add, remove, clear, stable depth sort and read.
//
// Input channel: i_valid with o_stall; one request item per handshake.
// Output channel: o_valid with i_stall; one result item per request.
// The block takes one request at a time. Read looks up one slot;
//   add/remove scan slots until a hit or the last slot; clear sweeps
//   every slot; sort compacts all slots, runs the merge passes over the
//   n entries and writes all slots back. The single read port on the
//   slot memory sets the scan rate.
// After reset a clearing pass empties the table; o_stall stays high
// during it. A result waits in the output register while the receiver
// stalls; a new request may be taken meanwhile, and its result is held
// until the previous one leaves.
// ============================================================================
module depth_sorted_slot_table
    import dsst_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
    localparam int SB = $clog2(SLOTS),
    localparam int CB = $clog2(SLOTS + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [2:0]                   i_req_type,
    input  wire logic [HANDLE_BITS-1:0]       i_entity_id,
    input  wire logic signed [DEPTH_BITS-1:0] i_entity_depth,
    input  wire logic [SB-1:0]                i_slot_index,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [SB-1:0]                     o_slot_number,
    output logic                              o_success,
    output logic [HANDLE_BITS-1:0]            o_slot_entity,
    output logic signed [DEPTH_BITS-1:0]      o_slot_depth,
    output logic                              o_slot_occupied,
    output logic [CB-1:0]                     o_entry_count,
    output logic                              o_needs_sort
);

    t_dp_cmd    w_cmd;
    t_dp_cmd    w_cmd_dp;
    t_dp_status w_status;

    always_comb begin
        w_cmd_dp = w_cmd;
        if (w_cmd.op == OP_LOAD) begin
            w_cmd_dp.read_sel = (i_req_type == REQ_READ);
        end
    end

    dsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    dsst_dp #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd_dp),
        .o_status        (w_status),
        .i_entity_id     (i_entity_id),
        .i_entity_depth  (i_entity_depth),
        .i_slot_index    (i_slot_index),
        .o_slot_number   (o_slot_number),
        .o_success       (o_success),
        .o_slot_entity   (o_slot_entity),
        .o_slot_depth    (o_slot_depth),
        .o_slot_occupied (o_slot_occupied),
        .o_entry_count   (o_entry_count),
        .o_needs_sort    (o_needs_sort)
    );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for depth_sorted_slot_table: directed requests, then
// random add/remove/read traffic with occasional sort, clear and spare
// request codes, checked item by item against a slot-table model.
// ============================================================================
module testbench;
    import dsst_pkg::*;

    localparam int NSLOT = 4096;
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    typedef struct {
        logic [2:0]         kind;
        logic [15:0]        id;
        logic signed [15:0] depth;
        logic [11:0]        idx;
    } req_t;

    typedef struct {
        logic [11:0]        slot;
        logic               ok;
        logic [15:0]        ent;
        logic signed [15:0] dep;
        logic               occ;
        logic [12:0]        count;
        logic               dirty;
    } res_t;

    class slot_scoreboard;
        logic               occ_q[NSLOT];
        logic [15:0]        hnd_q[NSLOT];
        logic signed [15:0] dep_q[NSLOT];
        int                 total;
        logic               dirty;
        res_t               waiting[$];
        int                 errors;

        function void wipe();
            for (int i = 0; i < NSLOT; i++) begin
                occ_q[i] = 0;
                hnd_q[i] = '0;
                dep_q[i] = '0;
            end
            total = 0;
            dirty = 0;
        endfunction

        function void reorder_by_depth();
            logic [15:0]        h[$];
            logic signed [15:0] d[$];
            logic [15:0]        kh;
            logic signed [15:0] kd;
            int                 j;
            for (int i = 0; i < NSLOT; i++) begin
                if (occ_q[i]) begin
                    h.push_back(hnd_q[i]);
                    d.push_back(dep_q[i]);
                end
            end
            for (int i = 1; i < h.size(); i++) begin
                kh = h[i];
                kd = d[i];
                j = i - 1;
                while (j >= 0 && d[j] > kd) begin
                    h[j+1] = h[j];
                    d[j+1] = d[j];
                    j--;
                end
                h[j+1] = kh;
                d[j+1] = kd;
            end
            for (int i = 0; i < NSLOT; i++) begin
                occ_q[i] = (i < h.size());
                hnd_q[i] = (i < h.size()) ? h[i] : '0;
                dep_q[i] = (i < h.size()) ? d[i] : '0;
            end
            total = h.size();
        endfunction

        function void note_request(req_t r);
            res_t e;
            e = '{slot: '0, ok: 0, ent: '0, dep: '0, occ: 0, count: '0, dirty: 0};
            case (r.kind)
                REQ_ADD: begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!occ_q[i]) begin
                            occ_q[i] = 1;
                            hnd_q[i] = r.id;
                            dep_q[i] = r.depth;
                            total++;
                            dirty = 1;
                            e.slot = 12'(i);
                            e.ok = 1;
                            break;
                        end
                    end
                end
                REQ_REMOVE: begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (occ_q[i] && hnd_q[i] == r.id) begin
                            occ_q[i] = 0;
                            hnd_q[i] = '0;
                            dep_q[i] = '0;
                            total--;
                            dirty = 1;
                            e.ok = 1;
                            break;
                        end
                    end
                end
                REQ_CLEAR: wipe();
                REQ_SORT: begin
                    reorder_by_depth();
                    dirty = 0;
                end
                REQ_READ: begin
                    e.slot = r.idx;
                    if (occ_q[r.idx]) begin
                        e.occ = 1;
                        e.ent = hnd_q[r.idx];
                        e.dep = dep_q[r.idx];
                    end
                end
                default: ;
            endcase
            e.count = 13'(total);
            e.dirty = dirty;
            waiting.push_back(e);
        endfunction

        function void check_result(res_t a);
            res_t e;
            if (waiting.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item slot=%0d", a.slot);
                return;
            end
            e = waiting.pop_front();
            if (a.slot !== e.slot || a.ok !== e.ok || a.ent !== e.ent || a.dep !== e.dep
                || a.occ !== e.occ || a.count !== e.count || a.dirty !== e.dirty) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp slot=%0d ok=%0b ent=%h dep=%0d occ=%0b cnt=%0d ns=%0b",
                             e.slot, e.ok, e.ent, e.dep, e.occ, e.count, e.dirty,
                             " got slot=%0d ok=%0b ent=%h dep=%0d occ=%0b cnt=%0d ns=%0b",
                             a.slot, a.ok, a.ent, a.dep, a.occ, a.count, a.dirty);
            end
        endfunction

        function logic [15:0] present_handle();
            logic [15:0] h[$];
            for (int i = 0; i < NSLOT; i++) if (occ_q[i]) h.push_back(hnd_q[i]);
            return h[$urandom_range(0, h.size() - 1)];
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic [2:0]         i_req_type = '0;
    logic [15:0]        i_entity_id = '0;
    logic signed [15:0] i_entity_depth = '0;
    logic [11:0]        i_slot_index = '0;
    logic               o_valid;
    logic               i_stall = 0;
    logic [11:0]        o_slot_number;
    logic               o_success;
    logic [15:0]        o_slot_entity;
    logic signed [15:0] o_slot_depth;
    logic               o_slot_occupied;
    logic [12:0]        o_entry_count;
    logic               o_needs_sort;

    slot_scoreboard sb = new();
    bit calm = 0;
    bit hold_req = 0;

    depth_sorted_slot_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_entity_id(i_entity_id),
        .i_entity_depth(i_entity_depth), .i_slot_index(i_slot_index),
        .o_valid(o_valid), .i_stall(i_stall), .o_slot_number(o_slot_number),
        .o_success(o_success), .o_slot_entity(o_slot_entity),
        .o_slot_depth(o_slot_depth), .o_slot_occupied(o_slot_occupied),
        .o_entry_count(o_entry_count), .o_needs_sort(o_needs_sort)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{slot: o_slot_number, ok: o_success, ent: o_slot_entity,
                              dep: o_slot_depth, occ: o_slot_occupied,
                              count: o_entry_count, dirty: o_needs_sort});
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1;
                repeat (400) @(posedge i_clk);
                i_stall <= 0;
                hold_req = 0;
            end else if (!calm && i_rst_n && $urandom_range(0, 7) == 0) begin
                i_stall <= 1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 0;
            end
        end
    end

    task automatic send(logic [2:0] kind, logic [15:0] id, logic signed [15:0] depth,
                        logic [11:0] idx);
        req_t r;
        r = '{kind: kind, id: id, depth: depth, idx: idx};
        i_valid <= 1;
        i_req_type <= kind;
        i_entity_id <= id;
        i_entity_depth <= depth;
        i_slot_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(r);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.waiting.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_depth();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int pick;
        sb.wipe();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        send(REQ_ADD, 16'h0000, 16'sh8000, 0);
        send(REQ_ADD, 16'hffff, 16'sh7fff, 0);
        send(REQ_ADD, 16'h1234, 16'sh0000, 0);
        send(REQ_ADD, 16'h0abc, 16'sh0000, 0);
        send(REQ_ADD, 16'h5555, 16'shffff, 0);
        send(REQ_READ, 16'h0000, 0, 12'd1);
        send(REQ_REMOVE, 16'h1234, 0, 0);
        send(REQ_READ, 16'h0000, 0, 12'd2);
        send(REQ_REMOVE, 16'h7777, 0, 0);
        send(REQ_ADD, 16'haaaa, 16'sh0000, 0);
        send(REQ_ADD, 16'h0abc, 16'sh7fff, 0);
        send(REQ_SORT, 0, 0, 0);
        for (int i = 0; i < 6; i++) send(REQ_READ, 0, 0, 12'(i));
        send(REQ_SORT, 0, 0, 0);
        send(REQ_SPARE_A, 16'hffff, 16'sh7fff, 12'hfff);
        send(REQ_SPARE_B, 0, 0, 0);
        send(REQ_SPARE_C, 0, 0, 0);
        send(REQ_CLEAR, 0, 0, 0);
        send(REQ_READ, 0, 0, 12'd0);

        drain();

        hold_req = 1;
        for (int n = 0; n < 1100; n++) begin
            if (n == 950) calm = 1;
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send(REQ_SORT, 16'($urandom), 16'($urandom), 12'($urandom));
            else if (pick < 3)
                send(REQ_CLEAR, 16'($urandom), 16'($urandom), 12'($urandom));
            else if (pick < 4)
                send(REQ_REMOVE, 16'($urandom), 16'($urandom), 12'($urandom));
            else if (pick < 6)
                send(3'(REQ_SPARE_A + $urandom_range(0, 2)), 16'($urandom), 16'($urandom),
                     12'($urandom));
            else if (pick < 36)
                send(REQ_READ, 16'($urandom), 16'($urandom),
                     $urandom_range(0, 1) ? 12'($urandom_range(0, 63)) : 12'($urandom));
            else if (sb.total > 0 && (pick < 60 || sb.total > 48))
                send(REQ_REMOVE, sb.present_handle(), 16'($urandom), 12'($urandom));
            else
                send(REQ_ADD, 16'($urandom), rand_depth(), 12'($urandom));
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #1000ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/dsst_pkg.sv
rtl/core/dsst_ctrl.sv
rtl/core/dsst_dp.sv
rtl/core/depth_sorted_slot_table.sv
verif/testbench.sv
